FILE: src/conv3x3_replicate_border_defines.svh
`ifndef CONV3X3_REPLICATE_BORDER_DEFINES_SVH
`define CONV3X3_REPLICATE_BORDER_DEFINES_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define C3RB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define C3RB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/c3rb_pkg.sv
`default_nettype none

package c3rb_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_THREE_CHANNEL = 3'd2,
    REG_COEF_TOP      = 3'd3,
    REG_COEF_MID      = 3'd4,
    REG_COEF_BOTTOM   = 3'd5
  } cfg_reg_t;

  typedef logic [3*PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic       action;
    logic [7:0] sample_ch0;
    logic [7:0] sample_ch1;
    logic [7:0] sample_ch2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_ch0;
    logic [7:0] result_ch1;
    logic [7:0] result_ch2;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic x0;
    logic y1;
    logic y2;
    logic tail;
  } s1_ctrl_t;

endpackage

`default_nettype wire

FILE: src/conv3x3_replicate_border.sv
`default_nettype none

// Streaming 3x3 convolution of raster-order pixels with replicated borders.
// One pixel is taken per clock; in_stall rises only while a finished result
// is held in the output register and out_stall is high. Result (r,c) leaves
// on the transfer of input (r+1,c+1), then runs through a five-register
// pipeline: line store read, window update, multiplies, sum, output register.
// After the last pixel of a frame, send image_width+1 drain items to flush
// the final row; frame_end marks the last result. The two line stores are
// single memories with one read and one write port each; a copy into the
// upper store that collides with the next read of the same column is
// forwarded. Coefficients are signed Q4.12, left coefficient in bits 15:0.
// Configuration may be written only while no transfer is in flight.

`include "conv3x3_replicate_border_defines.svh"

module conv3x3_replicate_border #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire c3rb_pkg::in_item_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      c3rb_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [c3rb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [c3rb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;

  logic [10:0] image_width_r;
  logic [15:0] image_height_r;
  logic        three_channel_r;
  logic [c3rb_pkg::CFG_DATA_W-1:0] coef_row_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 11'd640;
      image_height_r  <= 16'd480;
      three_channel_r <= 1'b1;
      coef_row_r[0]   <= '0;
      coef_row_r[1]   <= c3rb_pkg::CFG_DATA_W'(48'h0000_1000_0000);
      coef_row_r[2]   <= '0;
    end else if (cfg_wr_en) begin
      case (c3rb_pkg::cfg_reg_t'(cfg_index))
        c3rb_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[10:0];
        c3rb_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[15:0];
        c3rb_pkg::REG_THREE_CHANNEL: three_channel_r <= cfg_data[0];
        c3rb_pkg::REG_COEF_TOP:      coef_row_r[0]   <= cfg_data;
        c3rb_pkg::REG_COEF_MID:      coef_row_r[1]   <= cfg_data;
        c3rb_pkg::REG_COEF_BOTTOM:   coef_row_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  c3rb_pkg::out_item_t out_data_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic [WW-1:0] iw_ext;
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [CW-1:0] in_column_r;
  logic [CW-1:0] in_column_nxt;
  logic [15:0]   in_row_r;
  logic [15:0]   in_row_nxt;
  logic [CW-1:0] x;
  logic          tail;
  logic          last;
  logic          take;
  logic          acc_en;

  always_comb begin
    iw_ext = WW'(image_width_r);
    if (iw_ext == '0) begin
      w_eff = CW'(1);
    end else if (iw_ext > WW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(iw_ext);
    end
    h_eff = (image_height_r == '0) ? 16'd1 : image_height_r;
    tail  = in_row_r >= h_eff;
    if (!tail && in_column_r >= w_eff) begin
      x = w_eff - CW'(1);
    end else if (tail && in_column_r > w_eff) begin
      x = w_eff;
    end else begin
      x = in_column_r;
    end
    last   = tail && (x >= w_eff);
    take   = in_valid && adv && !(!tail && in_data.action == c3rb_pkg::ACT_DRAIN);
    acc_en = take && !last;

    in_column_nxt = in_column_r;
    in_row_nxt    = in_row_r;
    if (take) begin
      if (last) begin
        in_column_nxt = '0;
        in_row_nxt    = '0;
      end else if (!tail && (x + CW'(1) >= w_eff)) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + 16'd1;
      end else begin
        in_column_nxt = x + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r <= '0;
      in_row_r    <= '0;
    end else begin
      in_column_r <= in_column_nxt;
      in_row_r    <= in_row_nxt;
    end
  end

  c3rb_pkg::pix_t     px;
  c3rb_pkg::pix_t     s1_px_r;
  c3rb_pkg::s1_ctrl_t s1_ctrl_r;
  c3rb_pkg::pix_t     lower_q;
  c3rb_pkg::pix_t     upper_q;

  assign px = {in_data.sample_ch2, in_data.sample_ch1, in_data.sample_ch0};

  c3rb_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc_en   (acc_en),
    .acc_wr   (!tail),
    .acc_addr (x[AW-1:0]),
    .acc_px   (px),
    .lower_q  (lower_q),
    .upper_q  (upper_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r.valid <= take;
      s1_ctrl_r.last  <= last;
      s1_ctrl_r.x0    <= (x == '0);
      s1_ctrl_r.y1    <= (in_row_r >= 16'd1);
      s1_ctrl_r.y2    <= (in_row_r >= 16'd2);
      s1_ctrl_r.tail  <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r <= px;
    end
  end

  logic           s2_v;
  logic           s2_end;
  c3rb_pkg::win_t s2_win;

  c3rb_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctrl         (s1_ctrl_r),
    .mid_q        (lower_q),
    .upper_q      (upper_q),
    .px           (s1_px_r),
    .emit_valid_r (s2_v),
    .emit_end_r   (s2_end),
    .emit_win_r   (s2_win)
  );

  logic [8:0][c3rb_pkg::COEF_W-1:0] coef;
  logic [7:0] res [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r*3+c] = coef_row_r[r][c*c3rb_pkg::COEF_W +: c3rb_pkg::COEF_W];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [8:0][c3rb_pkg::PIX_W-1:0] lane_pix;
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_pix[r*3+c] = s2_win[r][c][l*c3rb_pkg::PIX_W +: c3rb_pkg::PIX_W];
        end
      end
    end
    c3rb_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .pix    (lane_pix),
      .coef   (coef),
      .result (res[l])
    );
  end

  logic s3_v_r;
  logic s4_v_r;
  logic s3_end_r;
  logic s4_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s3_v_r      <= s2_v;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_end_r              <= s2_end;
      s4_end_r              <= s3_end_r;
      out_data_r.result_ch0 <= res[0];
      out_data_r.result_ch1 <= three_channel_r ? res[1] : 8'd0;
      out_data_r.result_ch2 <= three_channel_r ? res[2] : 8'd0;
      out_data_r.frame_end  <= s4_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `C3RB_ASSERT_NEXT(a_frame_restart, clk, rst_n, take && last, (in_column_r == '0) && (in_row_r == '0), "counters not cleared after final transfer")
  `C3RB_ASSERT_NOW(a_addr_in_range, clk, rst_n, acc_en, x < w_eff, "line store column beyond row width")
  `C3RB_ASSERT_NOW(a_one_channel_zero, clk, rst_n, out_valid_r && !three_channel_r, (out_data_r.result_ch1 == 8'd0) && (out_data_r.result_ch2 == 8'd0), "extra channels not zero in one-channel mode")

endmodule

`default_nettype wire

FILE: src/c3rb_linebuf.sv
`default_nettype none

module c3rb_linebuf #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              acc_en,
  input  wire logic                              acc_wr,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      acc_addr,
  input  wire c3rb_pkg::pix_t                    acc_px,
  output      c3rb_pkg::pix_t                    lower_q,
  output      c3rb_pkg::pix_t                    upper_q
);

  localparam int AW = $clog2(MAX_WIDTH);

  c3rb_pkg::pix_t lower_mem [MAX_WIDTH];
  c3rb_pkg::pix_t upper_mem [MAX_WIDTH];

  c3rb_pkg::pix_t lower_rd_r;
  c3rb_pkg::pix_t upper_rd_r;
  c3rb_pkg::pix_t fwd_data_r;
  logic           fwd_r;
  logic           s1_wr_r;
  logic [AW-1:0]  s1_addr_r;

  always_ff @(posedge clk) begin
    if (adv && acc_en) begin
      lower_rd_r <= lower_mem[acc_addr];
      if (acc_wr) begin
        lower_mem[acc_addr] <= acc_px;
      end
    end
  end

  // The previous row entry, held in the lower store read register, moves up once its old value is read.
  always_ff @(posedge clk) begin
    if (adv && acc_en) begin
      upper_rd_r <= upper_mem[acc_addr];
    end
    if (adv && s1_wr_r) begin
      upper_mem[s1_addr_r] <= lower_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_wr_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (adv) begin
      s1_wr_r <= acc_en && acc_wr;
      fwd_r   <= s1_wr_r && acc_en && (s1_addr_r == acc_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r  <= acc_addr;
      fwd_data_r <= lower_rd_r;
    end
  end

  assign lower_q = lower_rd_r;
  assign upper_q = fwd_r ? fwd_data_r : upper_rd_r;

endmodule

`default_nettype wire

FILE: src/c3rb_window.sv
`default_nettype none

module c3rb_window (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire c3rb_pkg::s1_ctrl_t ctrl,
  input  wire c3rb_pkg::pix_t     mid_q,
  input  wire c3rb_pkg::pix_t     upper_q,
  input  wire c3rb_pkg::pix_t     px,
  output      logic               emit_valid_r,
  output      logic               emit_end_r,
  output      c3rb_pkg::win_t     emit_win_r
);

  c3rb_pkg::win_t win_r;
  c3rb_pkg::win_t win_nxt;
  c3rb_pkg::win_t rep;
  c3rb_pkg::win_t shf;
  c3rb_pkg::win_t fill;
  c3rb_pkg::win_t emit_win_nxt;
  c3rb_pkg::pix_t col [3];
  logic           emit;

  always_comb begin
    col[1] = mid_q;
    col[0] = ctrl.y2 ? upper_q : mid_q;
    col[2] = ctrl.tail ? mid_q : px;
    for (int r = 0; r < 3; r++) begin
      rep[r][0]  = win_r[r][1];
      rep[r][1]  = win_r[r][2];
      rep[r][2]  = win_r[r][2];
      shf[r][0]  = win_r[r][1];
      shf[r][1]  = win_r[r][2];
      shf[r][2]  = col[r];
      fill[r][0] = col[r];
      fill[r][1] = col[r];
      fill[r][2] = col[r];
    end
    if (ctrl.last) begin
      win_nxt      = rep;
      emit_win_nxt = rep;
    end else if (ctrl.x0) begin
      win_nxt      = fill;
      emit_win_nxt = rep;
    end else begin
      win_nxt      = shf;
      emit_win_nxt = shf;
    end
    emit = ctrl.valid && (ctrl.last || (ctrl.x0 ? ctrl.y2 : ctrl.y1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      emit_valid_r <= 1'b0;
    end else if (adv) begin
      emit_valid_r <= emit;
      if (ctrl.valid) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      emit_win_r <= emit_win_nxt;
      emit_end_r <= ctrl.last;
    end
  end

endmodule

`default_nettype wire

FILE: src/c3rb_lane.sv
`default_nettype none

module c3rb_lane #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic [8:0][c3rb_pkg::PIX_W-1:0]  pix,
  input  wire logic [8:0][c3rb_pkg::COEF_W-1:0] coef,
  output      logic [c3rb_pkg::PIX_W-1:0]    result
);

  localparam int PROD_W = c3rb_pkg::PIX_W + 1 + c3rb_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + 4;

  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic        [ACC_W-1:0]  sh;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= $signed({1'b0, pix[i]}) * $signed(coef[i]);
      end
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[i]);
    end
  end

  assign sh = ACC_W'(acc_r >>> COEF_FRAC_BITS);

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      result = '0;
    end else if (|sh[ACC_W-1:c3rb_pkg::PIX_W]) begin
      result = '1;
    end else begin
      result = sh[c3rb_pkg::PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire
